@@ rtl/core/rfbs_pkg.sv @@
`default_nettype none
package rfbs_pkg;
  localparam int FRAC_BITS_DEF = 24;
  localparam logic [63:0] OMEGA_Q48 = 64'd20525502622;
  localparam logic [63:0] GM_INT = 64'd399029944000000;
  localparam logic [63:0] ATMO_RADIUS_M = 64'd6388137;

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_IMPULSE = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_POS_X = 3'd0,
    CFG_POS_Y = 3'd1,
    CFG_POS_Z = 3'd2,
    CFG_VEL_X = 3'd3,
    CFG_VEL_Y = 3'd4,
    CFG_VEL_Z = 3'd5,
    CFG_MASS = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT_R,
    ST_GDIV,
    ST_UDIV,
    ST_GMUL,
    ST_ROT,
    ST_SQRT_V,
    ST_DRAG,
    ST_DDIV,
    ST_UPD,
    ST_OUT
  } state_t;

  // drag factor floor(0.5*1.293*0.01*Cd*2^40) per band, Q0.40; fastest band first
  // (Cd 0.184, 0.242, 0.270, 0.328, 0.347, 0.306, 0.141, else 0.230)
  function automatic logic [63:0] drag_k(input logic [2:0] b);
    logic [63:0] k;
    unique case (b)
      3'd0: k = 64'd1307935051;
      3'd1: k = 64'd1720218927;
      3'd2: k = 64'd1919252521;
      3'd3: k = 64'd2331536396;
      3'd4: k = 64'd2466594907;
      3'd5: k = 64'd2175152858;
      3'd6: k = 64'd1002276316;
      default: k = 64'd1634918814;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] band_speed(input logic [2:0] b);
    logic [63:0] s;
    unique case (b)
      3'd0: s = 64'd1360;
      3'd1: s = 64'd1020;
      3'd2: s = 64'd680;
      3'd3: s = 64'd510;
      3'd4: s = 64'd374;
      3'd5: s = 64'd340;
      default: s = 64'd238;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/rfbs_if.sv @@
`default_nettype none
interface rfbs_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [63:0] impulse_x;
  logic signed [63:0] impulse_y;
  logic signed [63:0] impulse_z;
  modport source (output valid, command, impulse_x, impulse_y, impulse_z, input ready);
  modport sink (input valid, command, impulse_x, impulse_y, impulse_z, output ready);
endinterface

interface rfbs_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [63:0] pos_x;
  logic signed [63:0] pos_y;
  logic signed [63:0] pos_z;
  logic signed [63:0] vel_x;
  logic signed [63:0] vel_y;
  logic signed [63:0] vel_z;
  logic in_atmosphere;
  logic saturated;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  in_atmosphere, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                in_atmosphere, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rotating_frame_ballistic_step.sv @@
`default_nettype none
// Ballistic state integrator in an Earth-fixed rotating frame. One request
// carries a command: step (advance one second, semi-implicit Euler with
// gravity, Coriolis, centrifugal and below 6388137 m Mach-banded drag), load
// (copy init registers into the state), impulse (add a vector to velocity),
// or no-op. Each request gives exactly one result with the state after it.
// Load, impulse and no-op go straight to the update. A step runs on one
// shared 64x64 multiplier and one shared bit-serial divide/square root
// unit, and its time is dominated by the seven divisions and two roots in
// the divide unit. The block takes no request while one is working.
// Config writes go straight to registers and are meant while idle.
module rotating_frame_ballistic_step #(
  parameter int FRAC_BITS = rfbs_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  rfbs_in_if.sink          in_ch,
  rfbs_out_if.source       out_ch
);
  rfbs_pkg::state_t state, state_next;

  logic [63:0] cfg_init [6];
  logic [19:0] mass_kg;
  logic [63:0] pos [3];
  logic [63:0] vel [3];
  logic signed [127:0] acc [3];
  logic [1:0] cmd;
  logic [63:0] imp [3];

  // scratch
  logic [127:0] r2, v2, lim2;
  logic [63:0] rr, gc, tk;
  logic [3:0] sub;      // sub-step within a state
  logic [1:0] ax;       // axis index
  logic [2:0] band;
  logic atm, sat;
  logic [127:0] tmp;

  // shared units
  logic mul_start, mul_done;
  logic [63:0] mul_a, mul_b;
  logic [127:0] mul_p;
  logic div_start, div_mode, div_done;
  logic [127:0] div_n, div_d, div_q;

  rfbs_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .p(mul_p));
  rfbs_div u_div (.clk, .rst, .start(div_start), .sqrt_mode(div_mode), .n(div_n),
                  .d(div_d), .done(div_done), .q(div_q));

  localparam logic [6:0] GSH = 7'(FRAC_BITS + 16);
  localparam logic [6:0] RSH = 7'(FRAC_BITS - 8);

  function automatic logic [63:0] sat64(input logic [127:0] a, inout logic f);
    if (a[127:63] == {65{a[63]}}) return a[63:0];
    f = 1'b1;
    return a[127] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
  endfunction

  function automatic logic [127:0] neg_if(input logic s, input logic [127:0] m);
    return s ? (~m + 128'd1) : m;
  endfunction

  logic [63:0] rs_raw, rs;
  logic [63:0] kq;
  assign rs_raw = rr >> RSH;
  assign rs = (rs_raw == 64'd0) ? 64'd1 : rs_raw;
  assign kq = rfbs_pkg::drag_k(band);

  // cfg
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cfg_init[i] <= '0;
      mass_kg <= 20'd1;
    end else if (cfg_we) begin
      if (cfg_index == rfbs_pkg::CFG_MASS) mass_kg <= cfg_data[19:0];
      else if (cfg_index < 3'(rfbs_pkg::CFG_MASS)) cfg_init[cfg_index] <= cfg_data;
    end
  end

  assign in_ch.ready = (state == rfbs_pkg::ST_IDLE);
  assign out_ch.valid = (state == rfbs_pkg::ST_OUT);
  assign out_ch.pos_x = pos[0];
  assign out_ch.pos_y = pos[1];
  assign out_ch.pos_z = pos[2];
  assign out_ch.vel_x = vel[0];
  assign out_ch.vel_y = vel[1];
  assign out_ch.vel_z = vel[2];
  assign out_ch.in_atmosphere = atm;
  assign out_ch.saturated = sat;

  always_ff @(posedge clk) begin
    if (rst) state <= rfbs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Sequencer: sub counts 0 = launch op, 1 = wait for done.
  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    div_start = 1'b0;
    div_mode = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    unique case (state)
      rfbs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == rfbs_pkg::CMD_STEP) state_next = rfbs_pkg::ST_SQ;
          else state_next = rfbs_pkg::ST_UPD;
        end
      end
      rfbs_pkg::ST_SQ: begin
        // sub/2 0..5: r_i^2 then v_i^2; sub/2 6: lim^2
        mul_start = (sub[0] == 1'b0);
        if (sub[3:1] < 3'd3) begin
          mul_a = rfbs_pkg::mag64(pos[sub[2:1]]);
        end else if (sub[3:1] < 3'd6) begin
          mul_a = rfbs_pkg::mag64(vel[2'(sub[3:1] - 3'd3)]);
        end else begin
          mul_a = rfbs_pkg::ATMO_RADIUS_M << FRAC_BITS;
        end
        mul_b = mul_a;
        if (mul_done && sub[3:1] == 3'd6) state_next = rfbs_pkg::ST_SQRT_R;
      end
      rfbs_pkg::ST_SQRT_R: begin
        // body at the origin: no root, no gravity
        div_mode = 1'b1;
        div_n = r2;
        div_start = (sub == 4'd0) && (r2 != 128'd0);
        if (r2 == 128'd0) state_next = rfbs_pkg::ST_ROT;
        else if (div_done) state_next = rfbs_pkg::ST_GDIV;
      end
      rfbs_pkg::ST_GDIV: begin
        // sub 0/1: rs^2 on mul; sub 2/3: divide
        mul_a = rs;
        mul_b = rs;
        mul_start = (sub == 4'd0);
        div_n = {64'd0, rfbs_pkg::GM_INT} << GSH;
        div_d = tmp;
        div_start = (sub == 4'd2);
        if (div_done) state_next = rfbs_pkg::ST_UDIV;
      end
      rfbs_pkg::ST_UDIV: begin
        div_n = {64'd0, rfbs_pkg::mag64(pos[ax])} << 32;
        div_d = {64'd0, rr};
        div_start = (sub == 4'd0);
        if (div_done) state_next = rfbs_pkg::ST_GMUL;
      end
      rfbs_pkg::ST_GMUL: begin
        mul_a = gc;
        mul_b = tmp[63:0];
        mul_start = (sub == 4'd0);
        if (mul_done) state_next = (ax == 2'd2) ? rfbs_pkg::ST_ROT : rfbs_pkg::ST_UDIV;
      end
      rfbs_pkg::ST_ROT: begin
        // sub/2: 0 vy*W, 1 vx*W, 2 x*W, 3 t*W, 4 y*W, 5 t*W
        mul_start = (sub[0] == 1'b0);
        mul_b = rfbs_pkg::OMEGA_Q48;
        unique case (sub[3:1])
          3'd0: mul_a = rfbs_pkg::mag64(vel[1]);
          3'd1: mul_a = rfbs_pkg::mag64(vel[0]);
          3'd2: mul_a = rfbs_pkg::mag64(pos[0]);
          3'd4: mul_a = rfbs_pkg::mag64(pos[1]);
          default: mul_a = rfbs_pkg::mag64(tmp[63:0]);
        endcase
        if (mul_done && sub[3:1] == 3'd5) begin
          state_next = (r2 < lim2) ? rfbs_pkg::ST_SQRT_V : rfbs_pkg::ST_UPD;
        end
      end
      rfbs_pkg::ST_SQRT_V: begin
        div_mode = 1'b1;
        div_n = v2;
        div_start = (sub == 4'd0);
        if (div_done) state_next = rfbs_pkg::ST_DRAG;
      end
      rfbs_pkg::ST_DRAG: begin
        // sub 0..13: band compares (even launch th^2), then 14/15: |v|*kq
        mul_start = (sub[0] == 1'b0);
        if (sub[3:1] == 3'd7) begin
          mul_a = tmp[63:0];
          mul_b = kq;
        end else begin
          mul_a = rfbs_pkg::band_speed(sub[3:1]) << FRAC_BITS;
          mul_b = mul_a;
        end
        if (mul_done && sub[3:1] == 3'd7) state_next = rfbs_pkg::ST_DDIV;
      end
      rfbs_pkg::ST_DDIV: begin
        mul_a = tk;
        mul_b = rfbs_pkg::mag64(vel[ax]);
        mul_start = (sub == 4'd0);
        div_n = tmp;
        div_d = {44'd0, ((mass_kg == 20'd0) ? 20'd1 : mass_kg), 64'd0} >> (64 - FRAC_BITS);
        div_start = (sub == 4'd2);
        if (div_done && ax == 2'd2) state_next = rfbs_pkg::ST_UPD;
      end
      rfbs_pkg::ST_UPD: state_next = rfbs_pkg::ST_OUT;
      rfbs_pkg::ST_OUT: if (out_ch.ready) state_next = rfbs_pkg::ST_IDLE;
      default: state_next = rfbs_pkg::ST_IDLE;
    endcase
  end

  logic [127:0] sp;    // signed-looking product of current ROT op
  logic sgn_rot;
  always_comb begin
    unique case (sub[3:1])
      3'd0: sgn_rot = vel[1][63];
      3'd1: sgn_rot = ~vel[0][63] & (vel[0] != 64'd0);
      3'd2: sgn_rot = pos[0][63];
      3'd4: sgn_rot = pos[1][63];
      default: sgn_rot = tmp[63];
    endcase
    sp = neg_if(sgn_rot, mul_p);
  end

  always_ff @(posedge clk) begin
    logic f;
    logic [63:0] nv [3];
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      sub <= '0;
      ax <= '0;
      atm <= 1'b0;
      sat <= 1'b0;
    end else begin
      f = 1'b0;
      for (int i = 0; i < 3; i++) nv[i] = vel[i];
      // drag loops over the axes inside one state: restart sub per axis
      if (state != state_next || (state == rfbs_pkg::ST_DDIV && div_done)) begin
        sub <= '0;
      end else if ((sub[0] == 1'b0 && (mul_start || div_start)) || mul_done || div_done) begin
        sub <= sub + 4'd1;
      end
      unique case (state)
        rfbs_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            cmd <= in_ch.command;
            imp[0] <= in_ch.impulse_x;
            imp[1] <= in_ch.impulse_y;
            imp[2] <= in_ch.impulse_z;
            r2 <= '0;
            v2 <= '0;
            band <= 3'd7;
            ax <= '0;
            atm <= 1'b0;
            sat <= 1'b0;
            for (int i = 0; i < 3; i++) acc[i] <= '0;
          end
        end
        rfbs_pkg::ST_SQ: if (mul_done) begin
          if (sub[3:1] < 3'd3) r2 <= r2 + mul_p;
          else if (sub[3:1] < 3'd6) v2 <= v2 + mul_p;
          else lim2 <= mul_p;
        end
        rfbs_pkg::ST_SQRT_R: if (div_done) rr <= div_q[63:0];
        rfbs_pkg::ST_GDIV: begin
          if (mul_done) tmp <= mul_p;
          if (div_done) gc <= (div_q[127:64] != 64'd0) ? '1 : div_q[63:0];
        end
        rfbs_pkg::ST_UDIV: if (div_done) tmp <= div_q;
        rfbs_pkg::ST_GMUL: if (mul_done) begin
          acc[ax] <= acc[ax] + neg_if(~pos[ax][63], mul_p >> 32);
          ax <= ax + 2'd1;
        end
        rfbs_pkg::ST_ROT: if (mul_done) begin
          unique case (sub[3:1])
            3'd0: acc[0] <= acc[0] + ($signed(sp) >>> 47);
            3'd1: acc[1] <= acc[1] + ($signed(sp) >>> 47);
            3'd3: acc[0] <= acc[0] + ($signed(sp) >>> 48);
            3'd5: acc[1] <= acc[1] + ($signed(sp) >>> 48);
            default: tmp <= 128'($signed(sp) >>> 48);
          endcase
          ax <= '0;
        end
        rfbs_pkg::ST_SQRT_V: if (div_done) begin
          tmp <= div_q;
          atm <= 1'b1;
        end
        rfbs_pkg::ST_DRAG: if (mul_done) begin
          if (sub[3:1] == 3'd7) tk <= 64'(mul_p >> 40);
          else if (band == 3'd7 && mul_p < v2) band <= sub[3:1];
        end
        rfbs_pkg::ST_DDIV: begin
          if (mul_done) tmp <= mul_p;
          if (div_done) begin
            acc[ax] <= acc[ax] + neg_if(~vel[ax][63], div_q);
            ax <= ax + 2'd1;
          end
        end
        rfbs_pkg::ST_UPD: begin
          unique case (cmd)
            rfbs_pkg::CMD_STEP: begin
              for (int i = 0; i < 3; i++) begin
                nv[i] = sat64({{64{vel[i][63]}}, vel[i]} + acc[i], f);
                vel[i] <= nv[i];
              end
              for (int i = 0; i < 3; i++)
                pos[i] <= sat64({{64{pos[i][63]}}, pos[i]} + {{64{nv[i][63]}}, nv[i]}, f);
            end
            rfbs_pkg::CMD_LOAD: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= cfg_init[i];
                vel[i] <= cfg_init[3 + i];
              end
            end
            rfbs_pkg::CMD_IMPULSE: begin
              for (int i = 0; i < 3; i++)
                vel[i] <= sat64({{64{vel[i][63]}}, vel[i]} + {{64{imp[i][63]}}, imp[i]}, f);
            end
            default: ;
          endcase
          sat <= f;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rfbs_mul.sv @@
`default_nettype none
// 64x64 unsigned multiply, four 32x32 partial products, one per cycle.
module rfbs_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic              done,
  output logic [127:0]      p
);
  logic [63:0] ra, rb;
  logic [2:0] cnt;
  logic busy;
  logic [63:0] pp;
  logic [31:0] ha, hb;

  assign ha = cnt[1] ? ra[63:32] : ra[31:0];
  assign hb = cnt[0] ? rb[63:32] : rb[31:0];
  assign pp = {32'd0, ha} * {32'd0, hb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 3'd0;
        ra <= a;
        rb <= b;
        p <= '0;
      end else if (busy) begin
        p <= p + ({64'd0, pp} << (7'd32 * ({6'd0, cnt[1]} + {6'd0, cnt[0]})));
        cnt <= cnt + 3'd1;
        if (cnt == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rfbs_div.sv @@
`default_nettype none
// Restoring divide, 128/128, one quotient bit a cycle. Also does integer
// square root (mode high), two radicand bits and one root bit a cycle, with its
// own compare and subtract.
module rfbs_div (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         sqrt_mode,
  input  wire logic [127:0] n,
  input  wire logic [127:0] d,
  output logic              done,
  output logic [127:0]      q
);
  logic busy, mode;
  logic [127:0] rn, rd, rem;
  logic [6:0] idx;
  logic [128:0] trial;
  logic [127:0] strial, scand;

  assign trial = {rem[127:0], rn[127]};
  // root step: remainder takes the next bit pair, candidate is 4*root + 1
  assign strial = {rem[125:0], rn[127:126]};
  assign scand = {62'd0, q[63:0], 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mode <= sqrt_mode;
        rn <= n;
        rd <= d;
        rem <= '0;
        q <= '0;
        idx <= sqrt_mode ? 7'd63 : 7'd127;
      end else if (busy) begin
        if (mode) begin
          rn <= {rn[125:0], 2'b00};
          if (strial >= scand) begin
            rem <= strial - scand;
            q <= {q[126:0], 1'b1};
          end else begin
            rem <= strial;
            q <= {q[126:0], 1'b0};
          end
        end else begin
          rn <= {rn[126:0], 1'b0};
          if (rd != 128'd0 && trial >= {1'b0, rd}) begin
            rem <= 128'(trial - {1'b0, rd});
            q <= {q[126:0], 1'b1};
          end else begin
            rem <= trial[127:0];
            q <= {q[126:0], 1'b0};
          end
        end
        idx <= idx - 7'd1;
        if (idx == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rfbs_checker.sv @@
`default_nettype none
module rfbs_sva (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // no new request while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("ready while result pending");
  // a result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // no result right after acceptance
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
  // ready returns once a result is taken
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not ready after result");
endmodule

bind rotating_frame_ballistic_step rfbs_sva u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
